// ===== rtl/core/canonical_huffman_encoder_top_defines.svh =====
// ---------------------------------------------------------------------------
// canonical huffman encoder assertion macros
// shared immediate-style wrappers for concurrent checks on the top level
// ---------------------------------------------------------------------------
`ifndef CANONICAL_HUFFMAN_ENCODER_TOP_DEFINES_SVH
`define CANONICAL_HUFFMAN_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define CHENC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define CHENC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/chenc_pkg.sv =====
// ---------------------------------------------------------------------------
// chenc_pkg
// shared constants, request codes and inter-module types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package chenc_pkg;

    localparam int DEF_MAX_CODE_LEN = 16;
    localparam int SYMBOL_COUNT     = 256;
    localparam int SYM_W            = 8;
    localparam int CLEN_IN_W        = 5;
    localparam int BYTE_W           = 8;
    localparam int PAD_W            = 4;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 16;

    // request kinds
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    // item handed from the lookup stage to the packer
    typedef struct packed {
        logic valid;
        logic flush;
    } pk_ctrl_t;

    // one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_present;
        logic [PAD_W-1:0]  pad_bits;
        logic              last;
    } res_t;

endpackage

// ===== rtl/core/canonical_huffman_encoder_top.sv =====
// ---------------------------------------------------------------------------
// canonical_huffman_encoder_top
// canonical huffman code table builder and msb-first byte packer
// ---------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                     tuser          tlast
//  s_        in   symbol[7:0], code_len[12:8]            req_type[1:0]  -
//  m_        out  out_byte[7:0], pad_bits[11:8]          byte_present   last
//
//  one input beat per cycle; a load writes the table ram in its accept cycle
//  an encode reads the ram at accept, then enters the packer from the lookup
//  stage; an encode that fills k bytes holds the packer for k output beats
//  reset clears the 256 entry valid bits at once, so no clearing pass is run
//  s_tready drops only while the lookup stage holds an item the packer
//  cannot take (packer busy with a multi-byte encode or output stalled)
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module canonical_huffman_encoder_top import chenc_pkg::*; #(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // symbol[7:0], code_len[12:8]
    input  logic [1:0]           s_tuser,   // req_type[1:0]
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_byte[7:0], pad_bits[11:8]
    output logic                 m_tuser,   // byte_present
    output logic                 m_tlast    // last result of the input item
);

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int NC_W  = MAX_CODE_LEN + 1;
    localparam int ENT_W = LEN_W + MAX_CODE_LEN;
    localparam int CL_W  = (LEN_W > CLEN_IN_W) ? LEN_W : CLEN_IN_W;

    // input field split
    logic                 accept;
    logic [1:0]           req;
    logic [SYM_W-1:0]     sym;
    logic [CLEN_IN_W-1:0] len_in;

    assign req    = s_tuser;
    assign sym    = s_tdata[SYM_W-1:0];
    assign len_in = s_tdata[SYM_W +: CLEN_IN_W];
    assign accept = s_tvalid && s_tready;

    // canonical code assignment state
    logic [NC_W-1:0]  next_code_reg, next_code_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;

    logic                    load_ok;
    logic [CL_W-1:0]         len_x, cur_x, max_x, shamt;
    logic [NC_W-1:0]         shifted;
    logic [MAX_CODE_LEN-1:0] code_mask, code_w;

    assign len_x = CL_W'(len_in);
    assign cur_x = CL_W'(cur_len_reg);
    assign max_x = CL_W'(MAX_CODE_LEN);

    // bad lengths (zero, too long, shorter than the last load) are dropped
    assign load_ok = accept && (req == REQ_LOAD) && (len_x != '0)
                     && (len_x <= max_x) && (len_x >= cur_x);

    assign shamt     = len_x - cur_x;
    assign shifted   = next_code_reg << shamt;
    assign code_mask = {MAX_CODE_LEN{1'b1}} >> (max_x - len_x);
    assign code_w    = shifted[MAX_CODE_LEN-1:0] & code_mask;

    always_comb begin
        next_code_next = next_code_reg;
        cur_len_next   = cur_len_reg;
        if (load_ok) begin
            // next code wraps at MAX_CODE_LEN + 1 bits
            next_code_next = shifted + NC_W'(1);
            cur_len_next   = LEN_W'(len_x);
        end
    end

    // table ram plus per-symbol valid bits; an unwritten entry reads as empty
    logic [SYMBOL_COUNT-1:0] tab_valid_reg;
    logic [ENT_W-1:0]        rd_entry;

    chenc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (load_ok),
        .waddr (sym),
        .wdata ({LEN_W'(len_x), code_w}),
        .re    (accept && (req == REQ_ENCODE)),
        .raddr (sym),
        .rdata (rd_entry)
    );

    // lookup stage: waits for ram data, held until the packer takes it
    logic     a_valid_reg, a_valid_next;
    logic     a_flush_reg;
    logic     a_hit_reg;
    logic     pk_take;
    pk_ctrl_t pk_ctrl;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = (req == REQ_ENCODE) || (req == REQ_FLUSH);
        end else if (pk_take) begin
            a_valid_next = 1'b0;
        end
    end

    assign s_tready = !a_valid_reg || pk_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_code_reg <= '0;
            cur_len_reg   <= '0;
            tab_valid_reg <= '0;
            a_valid_reg   <= 1'b0;
        end else begin
            next_code_reg <= next_code_next;
            cur_len_reg   <= cur_len_next;
            a_valid_reg   <= a_valid_next;
            if (load_ok) begin
                tab_valid_reg[sym] <= 1'b1;
            end
        end
        if (accept) begin
            a_flush_reg <= (req == REQ_FLUSH);
            a_hit_reg   <= tab_valid_reg[sym];
        end
    end

    assign pk_ctrl.valid = a_valid_reg;
    assign pk_ctrl.flush = a_flush_reg;

    // packer: pending bits, byte emission and output register
    res_t res;

    chenc_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .LEN_W        (LEN_W)
    ) u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctrl   (pk_ctrl),
        .in_len    (a_hit_reg ? rd_entry[ENT_W-1 -: LEN_W] : LEN_W'(0)),
        .in_code   (a_hit_reg ? rd_entry[MAX_CODE_LEN-1:0] : MAX_CODE_LEN'(0)),
        .in_take   (pk_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // result beat packing
    assign m_tdata = {{(M_TDATA_W - BYTE_W - PAD_W){1'b0}}, res.pad_bits, res.out_byte};
    assign m_tuser = res.byte_present;
    assign m_tlast = res.last;

endmodule

// ===== rtl/core/chenc_ram.sv =====
// ---------------------------------------------------------------------------
// chenc_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/chenc_packer.sv =====
// ---------------------------------------------------------------------------
// chenc_packer
// merges code bits into the pending byte and emits full bytes one per beat
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chenc_packer import chenc_pkg::*; #(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
    parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pk_ctrl_t                in_ctrl,
    input  logic [LEN_W-1:0]        in_len,
    input  logic [MAX_CODE_LEN-1:0] in_code,
    output logic                    in_take,
    output logic                    out_valid,
    input  logic                    out_ready,
    output res_t                    out_res
);

    localparam int ACC_W = MAX_CODE_LEN + 7;
    localparam int TOT_W = $clog2(MAX_CODE_LEN + 8);

    logic             busy_reg, busy_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic [6:0]       pend_bits_reg, pend_bits_next;
    logic [2:0]       pend_cnt_reg, pend_cnt_next;
    logic             out_valid_reg, out_valid_next;
    res_t             res_reg, res_next;

    logic             slot_free;
    logic [ACC_W-1:0] new_acc, src_acc;
    logic [TOT_W-1:0] new_tot, src_tot, left_tot;
    logic [2:0]       rem;
    logic [PAD_W-1:0] flush_pad;

    assign slot_free = !out_valid_reg || out_ready;
    assign new_acc   = (ACC_W'(pend_bits_reg) << in_len) | ACC_W'(in_code);
    assign new_tot   = TOT_W'(pend_cnt_reg) + TOT_W'(in_len);
    assign src_acc   = busy_reg ? acc_reg : new_acc;
    assign src_tot   = busy_reg ? tot_reg : new_tot;
    assign left_tot  = src_tot - TOT_W'(BYTE_W);
    assign flush_pad = PAD_W'(BYTE_W) - PAD_W'(pend_cnt_reg);

    always_comb begin
        in_take        = 1'b0;
        busy_next      = busy_reg;
        acc_next       = acc_reg;
        tot_next       = tot_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        rem            = src_tot[2:0];

        if (busy_reg || (in_ctrl.valid && !in_ctrl.flush)) begin
            if (src_tot >= TOT_W'(BYTE_W)) begin
                if (slot_free) begin
                    out_valid_next        = 1'b1;
                    res_next.out_byte     = BYTE_W'(src_acc >> left_tot);
                    res_next.byte_present = 1'b1;
                    res_next.pad_bits     = '0;
                    res_next.last         = (left_tot < TOT_W'(BYTE_W));
                    in_take               = !busy_reg;
                    if (left_tot >= TOT_W'(BYTE_W)) begin
                        busy_next = 1'b1;
                        acc_next  = src_acc;
                        tot_next  = left_tot;
                    end else begin
                        busy_next      = 1'b0;
                        rem            = left_tot[2:0];
                        pend_bits_next = src_acc[6:0] & ~(7'h7f << rem);
                        pend_cnt_next  = rem;
                    end
                end
            end else begin
                // fewer than eight bits in hand: nothing to emit
                in_take        = 1'b1;
                pend_bits_next = src_acc[6:0] & ~(7'h7f << rem);
                pend_cnt_next  = rem;
            end
        end else if (in_ctrl.valid && in_ctrl.flush && slot_free) begin
            in_take        = 1'b1;
            out_valid_next = 1'b1;
            res_next.last  = 1'b1;
            if (pend_cnt_reg != 3'd0) begin
                res_next.out_byte     = BYTE_W'({1'b0, pend_bits_reg} << flush_pad);
                res_next.byte_present = 1'b1;
                res_next.pad_bits     = flush_pad;
            end else begin
                res_next.out_byte     = '0;
                res_next.byte_present = 1'b0;
                res_next.pad_bits     = PAD_W'(BYTE_W);
            end
            pend_bits_next = '0;
            pend_cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
        acc_reg <= acc_next;
        tot_reg <= tot_next;
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/core/chenc_checker.sv =====
// ---------------------------------------------------------------------------
// chenc_checker
// port-level checks on the result channel, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "canonical_huffman_encoder_top_defines.svh"

module chenc_checker import chenc_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // a stalled beat holds its payload
    `CHENC_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

    // empty flush: zero byte, eight pad bits, last
    `CHENC_ASSERT_NOW(a_empty, aclk, aresetn, m_tvalid && !m_tuser, (m_tdata[7:0] == 8'd0) && (m_tdata[11:8] == 4'd8) && m_tlast, "bad empty flush beat")

    // padded bytes only close a flush
    `CHENC_ASSERT_NOW(a_pad_last, aclk, aresetn, m_tvalid && (m_tdata[11:8] != 4'd0), m_tlast && (m_tdata[11:8] <= 4'd8), "padded beat not last or pad too large")

    // upper tdata bits are fill
    `CHENC_ASSERT_NOW(a_fill, aclk, aresetn, m_tvalid, m_tdata[15:12] == 4'd0, "tdata fill bits not zero")

endmodule

bind canonical_huffman_encoder_top chenc_checker u_chenc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_canonical_huffman_encoder_top.sv =====
// ---------------------------------------------------------------------------
// tb_canonical_huffman_encoder_top
// self-checking bench for the canonical huffman encoder: load, encode and
// flush beats go in from a queue, an in-bench model of the code table and bit
// packer predicts every output beat, and the monitor checks each one in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_canonical_huffman_encoder_top;
    import chenc_pkg::*;

    localparam int         MAX_LEN        = DEF_MAX_CODE_LEN;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;    // reserved request kind, dropped
    localparam int         WATCHDOG_LIMIT = 2000;    // cycles with no beat on either side
    localparam int         TAIL_CYCLES    = 20;      // settle time after the last result
    localparam int         PHASE_ITEMS    = 567;

    // one input beat as the bench sees it
    typedef struct packed {
        logic [1:0] req;
        logic [7:0] sym;
        logic [4:0] clen;
    } huff_req_t;

    // clock, reset and block ports; the bench-driven ones are known from time zero
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // symbol[7:0], code_len[12:8]
    logic [1:0]           s_tuser  = '0;    // req_type[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // out_byte[7:0], pad_bits[11:8]
    logic                 m_tuser;          // byte_present
    logic                 m_tlast;          // last result of the input item

    // stimulus and scoreboard
    huff_req_t pending_items[$];
    res_t      expected_bytes[$];
    huff_req_t drv_item;
    logic [7:0] loaded_syms[$];
    int        gen_len       = 0;   // code length the block has reached, as the generator sees it
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        mismatches    = 0;
    int        stall_cycles  = 0;

    // shadow of the block state
    logic [4:0]  tab_len  [SYMBOL_COUNT];
    logic [15:0] tab_code [SYMBOL_COUNT];
    logic [16:0] nxt_code   = '0;
    logic [4:0]  cur_len    = '0;
    logic [6:0]  pend_bits  = '0;
    logic [2:0]  pend_cnt   = '0;

    initial begin
        for (int i = 0; i < SYMBOL_COUNT; i++) begin
            tab_len[i]  = '0;
            tab_code[i] = '0;
        end
    end

    always begin
        #6 aclk = ~aclk;
    end

    canonical_huffman_encoder_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // -----------------------------------------------------------------------
    // model of the table builder and packer, run once per accepted beat
    // -----------------------------------------------------------------------
    task automatic predict_huffman(input huff_req_t it);
        logic [63:0] grown;
        logic [63:0] acc;
        logic [63:0] sh;
        logic [31:0] mask;
        logic [7:0]  fbyte;
        int          shift;
        int          clen;
        int          total;
        int          n;
        int          pad;
        res_t        outs[2];
        res_t        r;
        n = 0;
        case (it.req)
            REQ_LOAD: begin
                // bad lengths are dropped without touching state
                if (it.clen != 0 && int'(it.clen) <= MAX_LEN && it.clen >= cur_len) begin
                    shift    = int'(it.clen) - int'(cur_len);
                    grown    = 64'(nxt_code) << shift;
                    nxt_code = grown[16:0];
                    cur_len  = it.clen;
                    mask     = (32'd1 << it.clen) - 32'd1;
                    tab_len[it.sym]  = it.clen;
                    // an oversubscribed code is simply cut down to its length
                    tab_code[it.sym] = nxt_code[15:0] & mask[15:0];
                    nxt_code = nxt_code + 17'd1;
                end
            end
            REQ_ENCODE: begin
                // an unloaded symbol has length zero and adds nothing
                clen  = int'(tab_len[it.sym]);
                acc   = (64'(pend_bits) << clen) | 64'(tab_code[it.sym]);
                total = int'(pend_cnt) + clen;
                while (total >= 8) begin
                    total = total - 8;
                    sh    = acc >> total;
                    r.out_byte     = sh[7:0];
                    r.byte_present = 1'b1;
                    r.pad_bits     = '0;
                    r.last         = 1'b0;
                    outs[n] = r;
                    n++;
                end
                for (int i = 0; i < n; i++) begin
                    if (i == n - 1) begin
                        outs[i].last = 1'b1;
                    end
                    expected_bytes.push_back(outs[i]);
                end
                sh        = acc & ((64'd1 << total) - 64'd1);
                pend_bits = sh[6:0];
                pend_cnt  = 3'(total);
            end
            REQ_FLUSH: begin
                if (pend_cnt != 0) begin
                    pad   = 8 - int'(pend_cnt);
                    fbyte = {1'b0, pend_bits} << pad;
                    r.out_byte     = fbyte;
                    r.byte_present = 1'b1;
                    r.pad_bits     = 4'(pad);
                end else begin
                    // empty flush still answers with one beat
                    r.out_byte     = '0;
                    r.byte_present = 1'b0;
                    r.pad_bits     = 4'd8;
                end
                r.last = 1'b1;
                expected_bytes.push_back(r);
                pend_bits = '0;
                pend_cnt  = '0;
            end
            default: begin
            end
        endcase
    endtask

    // -----------------------------------------------------------------------
    // stimulus helpers
    // -----------------------------------------------------------------------
    task automatic queue_item(input logic [1:0] req, input logic [7:0] sym,
                              input logic [4:0] clen);
        huff_req_t it;
        it.req  = req;
        it.sym  = sym;
        it.clen = clen;
        pending_items.push_back(it);
    endtask

    // tracks the length the block will have reached so random loads stay legal
    task automatic queue_load(input logic [7:0] sym, input logic [4:0] clen);
        if (clen != 0 && int'(clen) <= MAX_LEN && int'(clen) >= gen_len) begin
            gen_len = int'(clen);
            loaded_syms.push_back(sym);
        end
        queue_item(REQ_LOAD, sym, clen);
    endtask

    task automatic queue_encode(input logic [7:0] sym);
        queue_item(REQ_ENCODE, sym, 5'($urandom_range(0, 31)));
    endtask

    task automatic queue_flush();
        queue_item(REQ_FLUSH, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
    endtask

    // mostly legal loads and encodes of known symbols, with some noise mixed in
    task automatic queue_random_phase(input int target);
        int   counted;
        int   r;
        int   nl;
        logic [7:0] sym;
        counted = 0;
        while (counted < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                nl = gen_len;
                if (gen_len == 0 || (gen_len < MAX_LEN && $urandom_range(0, 3) == 0)) begin
                    nl = gen_len + $urandom_range(1, 2);
                    if (nl > MAX_LEN) begin
                        nl = MAX_LEN;
                    end
                end
                queue_load(8'($urandom_range(0, 255)), 5'(nl));
                counted++;
            end else if (r < 11) begin
                // beats the block drops: unused kind and illegal load lengths
                case ($urandom_range(0, 3))
                    0: queue_item(REQ_UNUSED, 8'($urandom_range(0, 255)),
                                  5'($urandom_range(0, 31)));
                    1: queue_load(8'($urandom_range(0, 255)), 5'd0);
                    2: queue_load(8'($urandom_range(0, 255)),
                                  5'($urandom_range(MAX_LEN + 1, 31)));
                    default: begin
                        if (gen_len > 1) begin
                            queue_load(8'($urandom_range(0, 255)),
                                       5'($urandom_range(1, gen_len - 1)));
                        end else begin
                            queue_load(8'($urandom_range(0, 255)), 5'd0);
                        end
                    end
                endcase
            end else if (r < 16) begin
                queue_flush();
                counted++;
            end else begin
                if (loaded_syms.size() != 0 && $urandom_range(0, 9) < 8) begin
                    sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                end else begin
                    sym = 8'($urandom_range(0, 255));
                end
                queue_encode(sym);
                counted++;
            end
        end
    endtask

    // checked on the falling edge so that queue and valid updates have settled
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_items.size() != 0 || s_tvalid || expected_bytes.size() != 0);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // -----------------------------------------------------------------------
    // sender: presents the next queued item once the current beat has gone
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_huffman(drv_item);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drv_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, drv_item.clen, drv_item.sym};
                    s_tuser  <= drv_item.req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // receiver: random back-pressure and in-order compare of result beats
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("result beat with none expected: out_byte %0h", m_tdata[7:0]);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("out_byte", want.out_byte, m_tdata[7:0]);
                    check_field("byte_present", want.byte_present, m_tuser);
                    check_field("pad_bits", want.pad_bits, m_tdata[11:8]);
                    check_field("last", want.last, m_tlast);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog: too long without a beat on either side ends the run
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_cycles = 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // test sequence
    // -----------------------------------------------------------------------
    initial begin
        send_idle_pct = 13;
        recv_idle_pct = 50;

        // empty flush, unloaded symbol, unused request kind, illegal lengths
        queue_flush();
        queue_encode(8'h00);
        queue_item(REQ_UNUSED, 8'hFF, 5'd31);
        queue_load(8'h10, 5'd0);
        queue_load(8'h11, 5'd17);
        // small table from the shortest length, a length drop and a reload
        queue_load(8'h00, 5'd1);
        queue_load(8'hFF, 5'd3);
        queue_load(8'hA5, 5'd3);
        queue_load(8'h5A, 5'd2);
        queue_load(8'hFF, 5'd4);
        // exactly one byte, then a flush with nothing pending
        queue_encode(8'h00);
        queue_encode(8'hFF);
        queue_encode(8'hA5);
        queue_flush();
        // partial byte padded on flush
        queue_encode(8'hA5);
        queue_flush();
        // a few more codes, one length up
        queue_load(8'h33, 5'd5);
        queue_load(8'h34, 5'd5);
        queue_load(8'h35, 5'd5);
        queue_encode(8'h33);
        queue_encode(8'h34);
        queue_encode(8'hFF);
        queue_encode(8'h35);
        queue_flush();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // sender rarely idles, receiver stalls half the time
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        // the other way round
        send_idle_pct = 50;
        recv_idle_pct = 13;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        // leave time for any stray result beat to show up
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
